// ===== rtl/smap_pkg.sv =====
`default_nettype none
package smap_pkg;

    localparam int ELEM_W = 32;
    // Index fields in the chain tokens are sized for the largest supported matrix.
    localparam int IDX_W  = 6;

    typedef enum logic [2:0] {
        CMD_WRA = 3'd0,
        CMD_WRB = 3'd1,
        CMD_ADD = 3'd2,
        CMD_SUB = 3'd3,
        CMD_MUL = 3'd4,
        CMD_POW = 3'd5,
        CMD_CMP = 3'd6,
        CMD_RDA = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [31:0]        value;
        logic [62:0]        exponent;
    } t_in_word;

    typedef struct packed {
        logic [31:0]        read_value;
        logic               equal;
    } t_out_word;

    typedef struct packed {
        logic               valid;
        logic               load;
        logic               first;
        logic               last;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   k;
        logic [IDX_W-1:0]   tag;
        logic [ELEM_W-1:0]  data;
    } t_tok;

    typedef struct packed {
        logic               done;
        logic [IDX_W-1:0]   row;
        logic [ELEM_W-1:0]  value;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/smap_cell.sv =====
`default_nettype none
module smap_cell
    import smap_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int COL     = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_tok i_tok,
    output t_tok      o_tok,
    output t_res      o_res
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // Column COL of the right-hand operand.
    logic [ELEM_W-1:0] ycol [MAX_DIM];

    t_tok              r_tok;
    logic              r_s1v;
    logic              r_first;
    logic              r_last;
    logic [IDX_W-1:0]  r_row;
    logic [ELEM_W-1:0] r_x;
    logic [ELEM_W-1:0] r_y;
    logic [ELEM_W-1:0] r_acc;
    logic              r_done;
    logic [IDX_W-1:0]  r_res_row;

    logic [2*ELEM_W-1:0] prod;
    logic [ELEM_W-1:0]   n_acc;

    always_ff @(posedge i_clk) begin
        if (i_tok.valid && i_tok.load && (i_tok.tag == IDX_W'(COL))) begin
            ycol[i_tok.k[IW-1:0]] <= i_tok.data;
        end
        r_y <= ycol[i_tok.k[IW-1:0]];
    end

    always_comb begin
        prod  = r_x * r_y;
        n_acc = (r_first ? '0 : r_acc) + prod[ELEM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_s1v       <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_tok     <= i_tok;
            r_s1v     <= i_tok.valid && !i_tok.load;
            r_first   <= i_tok.first;
            r_last    <= i_tok.last;
            r_row     <= i_tok.row;
            r_x       <= i_tok.data;
            r_done    <= r_s1v && r_last;
            r_res_row <= r_row;
            if (r_s1v) begin
                r_acc <= n_acc;
            end
        end
    end

    assign o_tok       = r_tok;
    assign o_res.done  = r_done;
    assign o_res.row   = r_res_row;
    assign o_res.value = r_acc;

endmodule
`default_nettype wire

// ===== rtl/smap_chain.sv =====
`default_nettype none
module smap_chain
    import smap_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_tok i_tok,
    output t_res      o_res [MAX_DIM]
);

    t_tok tok [MAX_DIM];

    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        t_tok tok_in;
        if (j == 0) begin : g_head
            assign tok_in = i_tok;
        end else begin : g_body
            assign tok_in = tok[j-1];
        end
        if (j == MAX_DIM - 1) begin : g_tail
            smap_cell #(.MAX_DIM(MAX_DIM), .COL(j)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (tok_in),
                .o_tok   (),
                .o_res   (o_res[j])
            );
        end else begin : g_mid
            smap_cell #(.MAX_DIM(MAX_DIM), .COL(j)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (tok_in),
                .o_tok   (tok[j]),
                .o_res   (o_res[j])
            );
        end
    end

endmodule
`default_nettype wire

// ===== rtl/square_matrix_alu_with_power.sv =====
// In a multiply each cell does one multiply-accumulate per cycle. A power does
// one multiply per set exponent bit and one per further bit. One word is in work
// at a time. After reset A and B are cleared in a pass during which no word is
// accepted; dim resets to 8.
`default_nettype none
module square_matrix_alu_with_power
    import smap_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_data
);

    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int IW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW        = (MAX_DIM > 1) ? $clog2(CELLS) : 1;
    localparam int NW        = $clog2(MAX_DIM + 1);
    localparam int DRAIN_LEN = MAX_DIM + 5;
    localparam int DW        = $clog2(DRAIN_LEN + 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SWEEP, S_LOAD, S_COMP, S_DRAIN, S_PSTEP, S_PSHIFT, S_FIN
    } t_state;
    typedef enum logic [1:0] {TK_EW, TK_LOAD, TK_COMP} t_tkind;
    typedef enum logic [1:0] {MK_AB, MK_AP, MK_PP} t_mk;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] i, input logic [IW-1:0] j);
        return AW'(32'(i) * MAX_DIM + 32'(j));
    endfunction

    logic [ELEM_W-1:0] mem_a [CELLS];
    logic [ELEM_W-1:0] mem_b [CELLS];
    logic [ELEM_W-1:0] mem_p [CELLS];

    t_state            r_state;
    logic [3:0]        r_dim;
    logic [AW-1:0]     r_clr;
    t_cmd              r_op;
    logic [62:0]       r_exp;
    logic              r_eq;
    logic [ELEM_W-1:0] r_res_val;
    logic              r_inside;
    logic [IW-1:0]     r_nm1;
    logic [IW-1:0]     r_ci;
    logic [IW-1:0]     r_cj;
    logic              r_powinit;
    t_mk               r_mk;
    logic [DW-1:0]     r_drain;
    logic              r_av;
    t_tkind            r_akind;
    logic [IW-1:0]     r_ai;
    logic [IW-1:0]     r_aj;
    logic [AW-1:0]     r_raddr;
    logic              r_tv;
    t_tkind            r_tkind;
    logic [IW-1:0]     r_ti;
    logic [IW-1:0]     r_tj;
    logic [ELEM_W-1:0] r_rd_a;
    logic [ELEM_W-1:0] r_rd_b;
    logic [ELEM_W-1:0] r_rd_p;
    t_tok              r_tok;
    logic              r_out_valid;
    t_out_word         r_out;

    t_res              res [MAX_DIM];

    logic [NW-1:0]     n_live;
    logic [IW-1:0]     nm1_live;
    logic              in_inside;
    logic [AW-1:0]     in_addr;
    logic              sw_last;
    logic [IW-1:0]     n_ci;
    logic [IW-1:0]     n_cj;
    logic [AW-1:0]     t_addr;
    logic [ELEM_W-1:0] ysrc;
    logic [ELEM_W-1:0] xsrc;
    logic              rs_en;
    logic [AW-1:0]     rs_addr;
    logic [ELEM_W-1:0] rs_data;
    logic              res_any;
    logic              wa_en;
    logic [AW-1:0]     wa_addr;
    logic [ELEM_W-1:0] wa_data;
    logic              wb_en;
    logic [AW-1:0]     wb_addr;
    logic [ELEM_W-1:0] wb_data;
    logic              wp_en;
    logic [AW-1:0]     wp_addr;
    logic [ELEM_W-1:0] wp_data;
    logic              ew_tag;

    always_comb begin
        if (r_dim == 4'd0) begin
            n_live = NW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            n_live = NW'(MAX_DIM);
        end else begin
            n_live = NW'(r_dim);
        end
        nm1_live  = IW'(n_live - NW'(1));
        in_inside = (32'(i_in_data.row) < 32'(n_live)) && (32'(i_in_data.col) < 32'(n_live));
        in_addr   = AW'(32'(i_in_data.row) * MAX_DIM + 32'(i_in_data.col));
    end

    always_comb begin
        sw_last = (r_ci == r_nm1) && (r_cj == r_nm1);
        if (r_cj == r_nm1) begin
            n_cj = '0;
            n_ci = r_ci + IW'(1);
        end else begin
            n_cj = r_cj + IW'(1);
            n_ci = r_ci;
        end
        t_addr = f_addr(r_ti, r_tj);
        ysrc   = (r_mk == MK_AB) ? r_rd_b : r_rd_p;
        xsrc   = (r_mk == MK_PP) ? r_rd_p : r_rd_a;
        ew_tag = r_tv && (r_tkind == TK_EW);
    end

    // At most one live cell finishes in any cycle.
    always_comb begin
        rs_en   = 1'b0;
        rs_addr = '0;
        rs_data = '0;
        res_any = 1'b0;
        for (int j = 0; j < MAX_DIM; j++) begin
            if (res[j].done) begin
                res_any = 1'b1;
            end
            if (res[j].done && (32'(j) <= 32'(r_nm1))) begin
                rs_en   = 1'b1;
                rs_addr = f_addr(res[j].row[IW-1:0], IW'(j));
                rs_data = res[j].value;
            end
        end
    end

    always_comb begin
        wa_en   = 1'b0;
        wa_addr = t_addr;
        wa_data = '0;
        if (r_state == S_CLR) begin
            wa_en   = 1'b1;
            wa_addr = r_clr;
        end else if (r_state == S_IDLE && i_in_valid && i_in_data.cmd == CMD_WRA && in_inside) begin
            wa_en   = 1'b1;
            wa_addr = in_addr;
            wa_data = i_in_data.value;
        end else if (ew_tag && r_op == CMD_ADD) begin
            wa_en   = 1'b1;
            wa_data = r_rd_a + r_rd_b;
        end else if (ew_tag && r_op == CMD_SUB) begin
            wa_en   = 1'b1;
            wa_data = r_rd_a - r_rd_b;
        end else if (ew_tag && r_op == CMD_POW) begin
            wa_en   = 1'b1;
            wa_data = (r_ti == r_tj) ? ELEM_W'(1) : '0;
        end else if (rs_en && r_mk != MK_PP) begin
            wa_en   = 1'b1;
            wa_addr = rs_addr;
            wa_data = rs_data;
        end

        wb_en   = 1'b0;
        wb_addr = in_addr;
        wb_data = i_in_data.value;
        if (r_state == S_CLR) begin
            wb_en   = 1'b1;
            wb_addr = r_clr;
            wb_data = '0;
        end else if (r_state == S_IDLE && i_in_valid && i_in_data.cmd == CMD_WRB && in_inside) begin
            wb_en = 1'b1;
        end

        wp_en   = 1'b0;
        wp_addr = t_addr;
        wp_data = r_rd_a;
        if (ew_tag && r_op == CMD_POW) begin
            wp_en = 1'b1;
        end else if (rs_en && r_mk == MK_PP) begin
            wp_en   = 1'b1;
            wp_addr = rs_addr;
            wp_data = rs_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wa_en) begin
            mem_a[wa_addr] <= wa_data;
        end
        if (wb_en) begin
            mem_b[wb_addr] <= wb_data;
        end
        if (wp_en) begin
            mem_p[wp_addr] <= wp_data;
        end
        r_rd_a <= mem_a[r_raddr];
        r_rd_b <= mem_b[r_raddr];
        r_rd_p <= mem_p[r_raddr];
    end

    smap_chain #(.MAX_DIM(MAX_DIM)) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (r_tok),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_dim       <= 4'd8;
            r_out_valid <= 1'b0;
            r_av        <= 1'b0;
            r_tv        <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_av    <= 1'b0;
            r_tv    <= r_av;
            r_tkind <= r_akind;
            r_ti    <= r_ai;
            r_tj    <= r_aj;

            r_tok.valid <= 1'b0;
            if (r_tv && r_tkind == TK_LOAD) begin
                r_tok.valid <= 1'b1;
                r_tok.load  <= 1'b1;
                r_tok.first <= 1'b0;
                r_tok.last  <= 1'b0;
                r_tok.row   <= '0;
                r_tok.k     <= IDX_W'(r_ti);
                r_tok.tag   <= IDX_W'(r_tj);
                r_tok.data  <= ysrc;
            end else if (r_tv && r_tkind == TK_COMP) begin
                r_tok.valid <= 1'b1;
                r_tok.load  <= 1'b0;
                r_tok.first <= (r_tj == '0);
                r_tok.last  <= (r_tj == r_nm1);
                r_tok.row   <= IDX_W'(r_ti);
                r_tok.k     <= IDX_W'(r_tj);
                r_tok.tag   <= '0;
                r_tok.data  <= xsrc;
            end

            if (ew_tag && r_op == CMD_CMP && r_rd_a != r_rd_b) begin
                r_eq <= 1'b0;
            end
            if (ew_tag && r_op == CMD_RDA && r_inside) begin
                r_res_val <= r_rd_a;
            end

            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= i_in_data.cmd;
                        r_exp     <= i_in_data.exponent;
                        r_eq      <= (i_in_data.cmd == CMD_CMP);
                        r_res_val <= '0;
                        r_inside  <= in_inside;
                        r_nm1     <= nm1_live;
                        r_ci      <= '0;
                        r_cj      <= '0;
                        r_powinit <= (i_in_data.cmd == CMD_POW);
                        case (i_in_data.cmd)
                            CMD_ADD, CMD_SUB, CMD_CMP, CMD_POW: begin
                                r_state <= S_SWEEP;
                            end
                            CMD_MUL: begin
                                r_mk    <= MK_AB;
                                r_state <= S_LOAD;
                            end
                            CMD_RDA: begin
                                r_av    <= 1'b1;
                                r_akind <= TK_EW;
                                r_raddr <= in_addr;
                                r_drain <= DW'(2);
                                r_state <= S_DRAIN;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SWEEP, S_LOAD, S_COMP: begin
                    r_av    <= 1'b1;
                    r_ai    <= r_ci;
                    r_aj    <= r_cj;
                    r_raddr <= f_addr(r_ci, r_cj);
                    r_ci    <= n_ci;
                    r_cj    <= n_cj;
                    case (r_state)
                        S_SWEEP: r_akind <= TK_EW;
                        S_LOAD:  r_akind <= TK_LOAD;
                        default: r_akind <= TK_COMP;
                    endcase
                    if (sw_last) begin
                        case (r_state)
                            S_LOAD: begin
                                r_ci    <= '0;
                                r_cj    <= '0;
                                r_state <= S_COMP;
                            end
                            S_COMP: begin
                                r_drain <= DW'(DRAIN_LEN);
                                r_state <= S_DRAIN;
                            end
                            default: begin
                                r_drain <= DW'(2);
                                r_state <= S_DRAIN;
                            end
                        endcase
                    end
                end
                S_DRAIN: begin
                    if (r_drain == '0) begin
                        if (r_op == CMD_POW) begin
                            if (r_powinit) begin
                                r_powinit <= 1'b0;
                                r_state   <= S_PSTEP;
                            end else if (r_mk == MK_AP) begin
                                r_state <= S_PSHIFT;
                            end else begin
                                r_state <= S_PSTEP;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_drain <= r_drain - DW'(1);
                    end
                end
                S_PSTEP: begin
                    if (r_exp == '0) begin
                        r_state <= S_FIN;
                    end else if (r_exp[0]) begin
                        r_mk    <= MK_AP;
                        r_ci    <= '0;
                        r_cj    <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_PSHIFT;
                    end
                end
                S_PSHIFT: begin
                    r_exp <= r_exp >> 1;
                    if (r_exp[62:1] != '0) begin
                        r_mk    <= MK_PP;
                        r_ci    <= '0;
                        r_cj    <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid      <= 1'b1;
                        r_out.read_value <= r_res_val;
                        r_out.equal      <= r_eq;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Cells only finish while a product is being computed or drained.
    a_res_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_any |-> (r_state == S_COMP || r_state == S_DRAIN))
        else $error("cell result outside a multiply");

    // Compute tokens only follow reads issued in the compute phase.
    a_comp_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tv && r_tkind == TK_COMP) |-> (r_state == S_COMP || r_state == S_DRAIN))
        else $error("compute token out of phase");

    // The equal flag is only ever reported for a compare.
    a_eq_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (!r_out.equal || r_op == CMD_CMP))
        else $error("equal flag on a non-compare word");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import smap_pkg::*;
();

    localparam int NDIM = 8;
    localparam int RAND_WORDS = 950;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int IN_W = $bits(t_in_word);

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = 4'd8;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;

    square_matrix_alu_with_power dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the matrices and the dimension register.
    logic [31:0] shadow_a [NDIM*NDIM];
    logic [31:0] shadow_b [NDIM*NDIM];
    logic [3:0]  shadow_dim;
    t_out_word   pending_results [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          long_hold = 1'b0;

    typedef logic [31:0] t_mat [NDIM*NDIM];

    function automatic int live_n();
        if (shadow_dim == 0) return 1;
        if (shadow_dim > NDIM) return NDIM;
        return int'(shadow_dim);
    endfunction

    function automatic t_mat mat_product(t_mat x, t_mat y, int n);
        t_mat r;
        logic [31:0] acc;
        r = x;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++) acc += x[i*NDIM+k] * y[k*NDIM+j];
                r[i*NDIM+j] = acc;
            end
        return r;
    endfunction

    function automatic t_out_word apply_word(t_in_word w);
        t_out_word res;
        int n;
        int idx;
        bit hit;
        t_mat base;
        logic [62:0] ex;
        res = '0;
        n = live_n();
        hit = (w.row < n) && (w.col < n);
        idx = w.row * NDIM + w.col;
        case (w.cmd)
            CMD_WRA: if (hit) shadow_a[idx] = w.value;
            CMD_WRB: if (hit) shadow_b[idx] = w.value;
            CMD_ADD, CMD_SUB: begin
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        shadow_a[i*NDIM+j] = (w.cmd == CMD_ADD) ?
                            shadow_a[i*NDIM+j] + shadow_b[i*NDIM+j] :
                            shadow_a[i*NDIM+j] - shadow_b[i*NDIM+j];
            end
            CMD_MUL: shadow_a = mat_product(shadow_a, shadow_b, n);
            CMD_POW: begin
                base = shadow_a;
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        shadow_a[i*NDIM+j] = (i == j) ? 32'd1 : 32'd0;
                ex = w.exponent;
                while (ex != 0) begin
                    if (ex[0]) shadow_a = mat_product(shadow_a, base, n);
                    ex = ex >> 1;
                    if (ex != 0) base = mat_product(base, base, n);
                end
            end
            CMD_CMP: begin
                res.equal = 1'b1;
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        if (shadow_a[i*NDIM+j] != shadow_b[i*NDIM+j]) res.equal = 1'b0;
            end
            default: if (hit) res.read_value = shadow_a[idx];
        endcase
        return res;
    endfunction

    // Receiver: stalls on its own pattern, with one long hold-off when asked.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (long_hold) i_out_stall <= 1'b1;
        else if (stall_phase[9:8] == 2'd3) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_out_data);
            end else begin
                t_out_word exp_w;
                exp_w = pending_results.pop_front();
                if (o_out_data.read_value !== exp_w.read_value ||
                    o_out_data.equal !== exp_w.equal) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %h equal %b, got %h %b",
                                 exp_w.read_value, exp_w.equal,
                                 o_out_data.read_value, o_out_data.equal);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Sends one word, with an optional check value typed in by the caller.
    task automatic send_word(t_in_word w, bit fixed, t_out_word fixed_res);
        t_out_word pred;
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        pred = apply_word(w);
        if (fixed && pred != fixed_res) begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees with predictor for %h", w);
        end
        pending_results.push_back(pred);
        if ($urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_set_dim(logic [3:0] d);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_dim = d;
    endtask

    function automatic t_in_word mk(t_cmd c, int r, int cl, logic [31:0] v, logic [62:0] e);
        t_in_word w;
        w.cmd = c; w.row = r[2:0]; w.col = cl[2:0]; w.value = v; w.exponent = e;
        return w;
    endfunction

    function automatic t_in_word random_word(int n);
        t_in_word w;
        int sel;
        w = IN_W'({$urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 45) w.cmd = ($urandom_range(0, 1) == 0) ? CMD_WRA : CMD_WRB;
        else if (sel < 55) w.cmd = CMD_RDA;
        else if (sel < 62) w.cmd = CMD_ADD;
        else if (sel < 69) w.cmd = CMD_SUB;
        else if (sel < 78) w.cmd = CMD_MUL;
        else if (sel < 88) w.cmd = CMD_POW;
        else w.cmd = CMD_CMP;
        // Mostly in-range indices, with some outside the corner in use.
        if ($urandom_range(0, 4) != 0) begin
            w.row = 3'($urandom_range(0, n - 1));
            w.col = 3'($urandom_range(0, n - 1));
        end
        if ($urandom_range(0, 3) == 0) w.value = $urandom_range(0, 3);
        if (w.cmd == CMD_POW && $urandom_range(0, 2) != 0)
            w.exponent = 63'($urandom_range(0, 20));
        return w;
    endfunction

    typedef struct {
        t_in_word  w;
        bit        fixed;
        t_out_word res;
    } t_row;

    t_row directed [$];

    initial begin
        t_out_word zero_res;
        t_out_word eq_res;
        t_out_word all_ones_res;
        logic [3:0] dims [6];
        zero_res = '0;
        eq_res = '0; eq_res.equal = 1'b1;
        all_ones_res = '0; all_ones_res.read_value = 32'hFFFF_FFFF;
        for (int i = 0; i < NDIM*NDIM; i++) begin
            shadow_a[i] = '0;
            shadow_b[i] = '0;
        end
        shadow_dim = 4'd8;

        directed = '{
            '{mk(CMD_CMP, 0, 0, 0, 0), 1'b1, eq_res},
            '{mk(CMD_RDA, 7, 7, 0, 0), 1'b1, zero_res},
            '{mk(CMD_WRA, 7, 7, 32'hFFFF_FFFF, '1), 1'b1, zero_res},
            '{mk(CMD_RDA, 7, 7, 32'h1234, '1), 1'b1, all_ones_res},
            '{mk(CMD_CMP, 0, 0, 0, 0), 1'b1, zero_res},
            '{mk(CMD_WRB, 7, 7, 32'h0000_0001, 0), 1'b1, zero_res},
            '{mk(CMD_ADD, 0, 0, 0, 0), 1'b1, zero_res},
            '{mk(CMD_RDA, 7, 7, 0, 0), 1'b1, zero_res},
            '{mk(CMD_SUB, 0, 0, 0, 0), 1'b0, zero_res},
            '{mk(CMD_RDA, 7, 7, 0, 0), 1'b1, all_ones_res},
            '{mk(CMD_WRA, 0, 1, 32'h8000_0001, 0), 1'b0, zero_res},
            '{mk(CMD_WRB, 1, 0, 32'h7FFF_FFFF, 0), 1'b0, zero_res},
            '{mk(CMD_MUL, 0, 0, 0, 0), 1'b0, zero_res},
            '{mk(CMD_RDA, 0, 0, 0, 0), 1'b0, zero_res},
            '{mk(CMD_POW, 0, 0, 0, 0), 1'b0, zero_res},
            '{mk(CMD_RDA, 3, 3, 0, 0), 1'b0, zero_res},
            '{mk(CMD_WRA, 2, 5, 32'd3, 0), 1'b0, zero_res},
            '{mk(CMD_POW, 0, 0, 0, 63'd5), 1'b0, zero_res},
            '{mk(CMD_POW, 0, 0, 0, {63{1'b1}}), 1'b0, zero_res},
            '{mk(CMD_RDA, 2, 5, 0, 0), 1'b0, zero_res},
            '{mk(CMD_CMP, 0, 0, 0, 0), 1'b0, zero_res}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) send_word(directed[r].w, directed[r].fixed, directed[r].res);

        // A fixed list of dims first, including the ones that get clamped.
        dims = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd8};
        foreach (dims[d]) begin
            drain_and_set_dim(dims[d]);
            send_word(mk(CMD_WRA, 1, 1, 32'hAB, 0), 1'b0, zero_res);
            send_word(mk(CMD_RDA, 1, 1, 0, 0), 1'b0, zero_res);
        end

        for (int s = 0; s < 5; s++) begin
            drain_and_set_dim((s == 4) ? 4'd8 : 4'($urandom_range(1, 5)));
            for (int i = 0; i < RAND_WORDS / 5; i++) begin
                if (s == 2 && i == 20) begin
                    fork
                        begin
                            long_hold = 1'b1;
                            repeat (400) @(posedge i_clk);
                            long_hold = 1'b0;
                        end
                    join_none
                end
                if ($urandom_range(0, 15) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(5, 40)) @(posedge i_clk);
                end
                send_word(random_word(live_n()), 1'b0, zero_res);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/smap_pkg.sv
rtl/smap_cell.sv
rtl/smap_chain.sv
rtl/square_matrix_alu_with_power.sv
tb/testbench.sv
